### rtl/dtlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dtlb_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TLB,
        S_TMIN,
        S_PAGE,
        S_PSCAN,
        S_PEND,
        S_EVICT,
        S_MAP,
        S_READ,
        S_RWAIT,
        S_CACHE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic tlb_hit;
        logic page_fault;
        logic page_evicted;
        logic cache_hit;
        logic frame_number;
    } result_t;

    localparam int STAMP_W = 32;
    localparam int VA_W    = 10;

endpackage
`default_nettype wire

### rtl/dtlb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dtlb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/data_tlb_page_cache_model.sv
// Data-side TLB, page table and cache model. One word in (address, timestamp), one word out
// (tlb_hit, page_fault, page_evicted, cache_hit, frame_number). Items are handled one at a
// time. An access with no TLB replacement walk and no page eviction passes the TLB lookup,
// page check, page memory read and wait, and cache lookup, then loads its result once the
// output register is free, and the next word is accepted. A page fault to a free frame skips
// the page memory read and maps the page. A TLB miss with every entry valid adds a walk for
// the oldest stamp. A page fault with all frames in use scans the page memory (one read port)
// at one read per cycle, then finishes the last compare and evicts, in place of the read. A
// result waits in the output register while the next word is already accepted.
`timescale 1ns / 1ps
`default_nettype none
module data_tlb_page_cache_model #(
    parameter int ADDRESS_SPACE = 1024,
    parameter int PAGE_BYTES    = 16,
    parameter int MEMORY_BYTES  = 32,
    parameter int CACHE_BYTES   = 16,
    parameter int BLOCK_BYTES   = 4,
    parameter int WAYS          = 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // virtual_address[9:0], access_time[41:10], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // tlb_hit, page_fault, page_evicted, cache_hit,
                                        // frame_number, zero
);

    localparam int NPAGES_R  = ADDRESS_SPACE / PAGE_BYTES;
    localparam int NPAGES    = (NPAGES_R > 0) ? NPAGES_R : 1;
    localparam int NTLB      = ((NPAGES / 4) > 0) ? (NPAGES / 4) : 1;
    localparam int NFRAMES_R = MEMORY_BYTES / PAGE_BYTES;
    localparam int NFRAMES   = (NFRAMES_R > 0) ? NFRAMES_R : 1;
    localparam int NBLOCKS_R = CACHE_BYTES / BLOCK_BYTES;
    localparam int NBLOCKS   = (NBLOCKS_R > 0) ? NBLOCKS_R : 1;
    localparam int NSETS     = ((NBLOCKS / WAYS) > 0) ? (NBLOCKS / WAYS) : 1;
    localparam int NLINES    = NSETS * WAYS;
    localparam int OFF_BITS  = $clog2(PAGE_BYTES);
    localparam int FRAME_BITS = $clog2(NFRAMES);
    localparam int FW        = (FRAME_BITS > 0) ? FRAME_BITS : 1;
    localparam int VPN_W     = ($clog2(NPAGES) > 0) ? $clog2(NPAGES) : 1;
    localparam int TW        = ($clog2(NTLB) > 0) ? $clog2(NTLB) : 1;
    localparam int NFW       = $clog2(NFRAMES + 1);
    localparam int BLK_SH    = $clog2(BLOCK_BYTES);
    localparam int IDX_BITS  = $clog2(NSETS);
    localparam int LW        = ($clog2(NLINES) > 0) ? $clog2(NLINES) : 1;
    localparam int PHYS_W    = FW + OFF_BITS;
    localparam int SW        = dtlb_pkg::STAMP_W;
    localparam int RAM_W     = SW + FW;

    dtlb_pkg::state_t state_reg, state_next;

    logic [dtlb_pkg::VA_W-1:0] va_reg;
    logic [SW-1:0]             now_reg;
    logic [VPN_W-1:0]          vpn;
    logic [OFF_BITS-1:0]       blk;
    logic [31:0]               addr_w;

    logic [VPN_W-1:0] tlb_tag_reg   [NTLB];
    logic [SW-1:0]    tlb_stamp_reg [NTLB];
    logic [NTLB-1:0]  tlb_valid_reg;
    logic [NPAGES-1:0] mapped_reg;
    logic [NFW-1:0]   next_frame_reg;
    logic             full_reg;

    logic [NLINES-1:0] line_valid_reg;
    logic [NLINES-1:0] line_mru_reg;
    logic [PHYS_W-1:0] line_tag_reg  [NLINES];
    logic [VPN_W-1:0]  line_page_reg [NLINES];

    logic [TW-1:0]    tcnt_reg;
    logic [TW-1:0]    tmin_reg;
    logic [VPN_W-1:0] pcnt_reg;
    logic [VPN_W-1:0] pidx_reg;
    logic             pv_reg;
    logic             pany_reg;
    logic [VPN_W-1:0] ploc_reg;
    logic [SW-1:0]    pmin_reg;
    logic [FW-1:0]    frame_reg;
    dtlb_pkg::result_t res_reg;
    dtlb_pkg::result_t out_reg;
    logic             out_valid_reg;

    logic            ram_we;
    logic [VPN_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic [FW-1:0]   fval;

    logic            hit_any;
    logic [TW-1:0]   hit_idx;
    logic            free_any;
    logic [TW-1:0]   free_idx;
    logic            fault;

    logic [PHYS_W-1:0] phys;
    logic [PHYS_W-1:0] ctag;
    int                cbase;
    logic              chit;
    logic [LW-1:0]     cway_idx;
    logic [WAYS-1:0]   mru_new;

    assign addr_w = 32'(va_reg) & 32'(ADDRESS_SPACE - 1);
    assign vpn    = VPN_W'(addr_w >> OFF_BITS);
    assign blk    = OFF_BITS'(addr_w >> BLK_SH);
    assign fval   = (FRAME_BITS > 0) ? FW'(next_frame_reg) : '0;
    assign fault  = !res_reg.tlb_hit && !mapped_reg[vpn];

    dtlb_ram #(
        .DEPTH (1 << VPN_W),
        .WIDTH (RAM_W)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vpn),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == dtlb_pkg::S_MAP);
    assign ram_wdata = {now_reg, fval};
    assign ram_raddr = (state_reg == dtlb_pkg::S_PSCAN) ? pcnt_reg : vpn;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < NTLB; i++)
        begin
            if (tlb_valid_reg[i] && tlb_tag_reg[i] == vpn)
            begin
                hit_any = 1'b1;
                hit_idx = TW'(i);
            end
        end
        for (int i = NTLB - 1; i >= 0; i--)
        begin
            if (!tlb_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = TW'(i);
            end
        end
    end

    always_comb
    begin
        logic [WAYS-1:0] wv;
        logic [WAYS-1:0] wm;
        logic            found;
        int              way;
        phys  = {frame_reg, blk};
        ctag  = phys >> IDX_BITS;
        cbase = int'(phys & PHYS_W'(NSETS - 1)) * WAYS;
        chit  = 1'b0;
        way   = 0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            wv[w] = line_valid_reg[LW'(cbase + w)];
            wm[w] = line_mru_reg[LW'(cbase + w)];
            if (wv[w] && line_tag_reg[LW'(cbase + w)] == ctag)
            begin
                chit = 1'b1;
                way  = w;
            end
        end
        if (!chit)
        begin
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (!wm[w])
                begin
                    way   = w;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                way = 0;
            end
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (!wv[w])
                begin
                    way = w;
                end
            end
        end
        cway_idx = LW'(cbase + way);
        mru_new  = wm | (WAYS'(1) << way);
        if (&mru_new)
        begin
            mru_new = WAYS'(1) << way;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            dtlb_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = dtlb_pkg::S_TLB;
                end
            end
            dtlb_pkg::S_TLB:
            begin
                if (!hit_any && !free_any && NTLB > 1)
                begin
                    state_next = dtlb_pkg::S_TMIN;
                end
                else
                begin
                    state_next = dtlb_pkg::S_PAGE;
                end
            end
            dtlb_pkg::S_TMIN:
            begin
                if (tcnt_reg == TW'(NTLB - 1))
                begin
                    state_next = dtlb_pkg::S_PAGE;
                end
            end
            dtlb_pkg::S_PAGE:
            begin
                if (!fault)
                begin
                    state_next = dtlb_pkg::S_READ;
                end
                else if (full_reg || next_frame_reg >= NFW'(NFRAMES))
                begin
                    state_next = dtlb_pkg::S_PSCAN;
                end
                else
                begin
                    state_next = dtlb_pkg::S_MAP;
                end
            end
            dtlb_pkg::S_PSCAN:
            begin
                if (pcnt_reg == VPN_W'(NPAGES - 1))
                begin
                    state_next = dtlb_pkg::S_PEND;
                end
            end
            dtlb_pkg::S_PEND:  state_next = dtlb_pkg::S_EVICT;
            dtlb_pkg::S_EVICT: state_next = dtlb_pkg::S_MAP;
            dtlb_pkg::S_MAP:   state_next = dtlb_pkg::S_CACHE;
            dtlb_pkg::S_READ:  state_next = dtlb_pkg::S_RWAIT;
            dtlb_pkg::S_RWAIT: state_next = dtlb_pkg::S_CACHE;
            dtlb_pkg::S_CACHE: state_next = dtlb_pkg::S_OUT;
            dtlb_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = dtlb_pkg::S_IDLE;
                end
            end
            default:           state_next = dtlb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtlb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg  <= '0;
            mapped_reg     <= '0;
            next_frame_reg <= '0;
            full_reg       <= 1'b0;
            line_valid_reg <= '0;
            line_mru_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pv_reg         <= 1'b0;
            for (int i = 0; i < NTLB; i++)
            begin
                tlb_tag_reg[i]   <= '0;
                tlb_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == dtlb_pkg::S_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                dtlb_pkg::S_TLB:
                begin
                    if (hit_any)
                    begin
                        tlb_stamp_reg[hit_idx] <= now_reg;
                    end
                    else if (free_any)
                    begin
                        tlb_valid_reg[free_idx] <= 1'b1;
                        tlb_tag_reg[free_idx]   <= vpn;
                        tlb_stamp_reg[free_idx] <= now_reg;
                    end
                    else if (NTLB == 1)
                    begin
                        tlb_tag_reg[0]   <= vpn;
                        tlb_stamp_reg[0] <= now_reg;
                    end
                end
                dtlb_pkg::S_TMIN:
                begin
                    if (tcnt_reg == TW'(NTLB - 1))
                    begin
                        if (tlb_stamp_reg[tcnt_reg] < tlb_stamp_reg[tmin_reg])
                        begin
                            tlb_tag_reg[tcnt_reg]   <= vpn;
                            tlb_stamp_reg[tcnt_reg] <= now_reg;
                        end
                        else
                        begin
                            tlb_tag_reg[tmin_reg]   <= vpn;
                            tlb_stamp_reg[tmin_reg] <= now_reg;
                        end
                    end
                end
                dtlb_pkg::S_PAGE:
                begin
                    pv_reg <= 1'b0;
                    if (fault && next_frame_reg >= NFW'(NFRAMES))
                    begin
                        full_reg       <= 1'b1;
                        next_frame_reg <= '0;
                    end
                end
                dtlb_pkg::S_PSCAN:
                begin
                    pv_reg <= 1'b1;
                end
                dtlb_pkg::S_PEND:
                begin
                    pv_reg <= 1'b0;
                end
                dtlb_pkg::S_EVICT:
                begin
                    mapped_reg[ploc_reg] <= 1'b0;
                    for (int i = 0; i < NTLB; i++)
                    begin
                        if (tlb_tag_reg[i] == ploc_reg)
                        begin
                            tlb_valid_reg[i] <= 1'b0;
                        end
                    end
                    for (int i = 0; i < NLINES; i++)
                    begin
                        if (line_page_reg[i] == ploc_reg)
                        begin
                            line_valid_reg[i] <= 1'b0;
                        end
                    end
                end
                dtlb_pkg::S_MAP:
                begin
                    mapped_reg[vpn] <= 1'b1;
                    next_frame_reg  <= next_frame_reg + NFW'(1);
                end
                dtlb_pkg::S_CACHE:
                begin
                    line_valid_reg[cway_idx] <= 1'b1;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        line_mru_reg[LW'(cbase + w)] <= mru_new[w];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_reg && mapped_reg[pidx_reg] &&
            (!pany_reg || ram_rdata[FW +: SW] < pmin_reg))
        begin
            pany_reg <= 1'b1;
            ploc_reg <= pidx_reg;
            pmin_reg <= ram_rdata[FW +: SW];
        end
        case (state_reg)
            dtlb_pkg::S_IDLE:
            begin
                va_reg   <= s_tdata[dtlb_pkg::VA_W-1:0];
                now_reg  <= s_tdata[dtlb_pkg::VA_W +: SW];
                res_reg  <= '0;
                tcnt_reg <= TW'(1);
                tmin_reg <= '0;
            end
            dtlb_pkg::S_TLB:
            begin
                res_reg.tlb_hit <= hit_any;
            end
            dtlb_pkg::S_TMIN:
            begin
                tcnt_reg <= tcnt_reg + TW'(1);
                if (tlb_stamp_reg[tcnt_reg] < tlb_stamp_reg[tmin_reg])
                begin
                    tmin_reg <= tcnt_reg;
                end
            end
            dtlb_pkg::S_PAGE:
            begin
                res_reg.page_fault <= fault;
                pcnt_reg <= '0;
                pany_reg <= 1'b0;
            end
            dtlb_pkg::S_PSCAN:
            begin
                pidx_reg <= pcnt_reg;
                pcnt_reg <= pcnt_reg + VPN_W'(1);
            end
            dtlb_pkg::S_EVICT:
            begin
                res_reg.page_evicted <= 1'b1;
            end
            dtlb_pkg::S_MAP:
            begin
                frame_reg <= fval;
            end
            dtlb_pkg::S_RWAIT:
            begin
                frame_reg <= ram_rdata[FW-1:0];
            end
            dtlb_pkg::S_CACHE:
            begin
                res_reg.cache_hit    <= chit;
                res_reg.frame_number <= frame_reg[0];
                if (!chit)
                begin
                    line_tag_reg[cway_idx]  <= ctag;
                    line_page_reg[cway_idx] <= vpn;
                end
            end
            dtlb_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.frame_number, out_reg.cache_hit,
                       out_reg.page_evicted, out_reg.page_fault, out_reg.tlb_hit};

    a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("eviction without page fault");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[1])
        else $error("tlb hit reported with page fault");

    a_map_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dtlb_pkg::S_MAP |=> mapped_reg[vpn])
        else $error("mapped page not marked");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dtlb_pkg::S_EVICT |-> full_reg)
        else $error("eviction before memory full");

endmodule
`default_nettype wire

### tb/data_tlb_page_cache_model_tb.sv
`timescale 1ns / 1ps
module data_tlb_page_cache_model_tb;

    localparam int NPAGES = 64;
    localparam int NTLB = 16;
    localparam int NFRAMES = 2;
    localparam int NSETS = 4;
    localparam int OFF_BITS = 4;
    localparam int IDX_BITS = 2;
    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;

    data_tlb_page_cache_model u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    logic [5:0] tlb_tag [NTLB];
    logic tlb_vld [NTLB];
    logic [31:0] tlb_stamp [NTLB];
    logic pg_mapped [NPAGES];
    logic pg_frame [NPAGES];
    logic [31:0] pg_stamp [NPAGES];
    int unsigned frame_ptr;
    logic mem_full;
    logic ln_vld [NSETS];
    logic [2:0] ln_tag [NSETS];
    logic [5:0] ln_page [NSETS];

    logic [47:0] pending_words [$];
    dtlb_pkg::result_t expected_results [$];
    int errors = 0;
    int results_seen = 0;
    int faults_seen = 0;
    int evictions_seen = 0;
    int tlb_hits_seen = 0;
    int cache_hits_seen = 0;
    int unsigned cycles = 0;
    logic quiet = 1'b0;
    logic hold_sink = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;

    function automatic dtlb_pkg::result_t translate_access(logic [9:0] va, logic [31:0] now);
        dtlb_pkg::result_t r;
        logic [5:0] vpn;
        int slot;
        int loc;
        logic found;
        logic [2:0] phys;
        logic [4:0] pa;
        int set;
        r = '0;
        vpn = va[9:4];
        slot = 0;
        for (int i = 0; i < NTLB; i++)
            if (tlb_vld[i] && tlb_tag[i] == vpn)
            begin
                r.tlb_hit = 1'b1;
                slot = i;
            end
        if (!r.tlb_hit)
        begin
            found = 1'b0;
            for (int i = 0; i < NTLB && !found; i++)
                if (!tlb_vld[i])
                begin
                    slot = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                slot = 0;
                for (int i = 1; i < NTLB; i++)
                    if (tlb_stamp[i] < tlb_stamp[slot])
                        slot = i;
            end
            tlb_vld[slot] = 1'b1;
            tlb_tag[slot] = vpn;
        end
        tlb_stamp[slot] = now;
        if (!r.tlb_hit && !pg_mapped[vpn])
        begin
            r.page_fault = 1'b1;
            if (frame_ptr >= NFRAMES)
            begin
                mem_full = 1'b1;
                frame_ptr = 0;
            end
            if (mem_full)
            begin
                found = 1'b0;
                loc = 0;
                for (int i = 0; i < NPAGES; i++)
                    if (pg_mapped[i] && (!found || pg_stamp[i] < pg_stamp[loc]))
                    begin
                        loc = i;
                        found = 1'b1;
                    end
                pg_mapped[loc] = 1'b0;
                r.page_evicted = 1'b1;
                for (int i = 0; i < NTLB; i++)
                    if (tlb_tag[i] == loc[5:0])
                        tlb_vld[i] = 1'b0;
            end
            pg_frame[vpn] = frame_ptr[0];
            frame_ptr++;
            pg_mapped[vpn] = 1'b1;
            pg_stamp[vpn] = now;
        end
        for (int i = 0; i < NSETS; i++)
            if (ln_vld[i])
                ln_vld[i] = pg_mapped[ln_page[i]];
        pa = {pg_frame[vpn], va[5:2]};
        set = pa[1:0];
        phys = pa[4:2];
        if (ln_vld[set] && ln_tag[set] == phys)
            r.cache_hit = 1'b1;
        else
        begin
            ln_vld[set] = 1'b1;
            ln_page[set] = vpn;
            ln_tag[set] = phys;
        end
        r.frame_number = pg_frame[vpn];
        return r;
    endfunction

    task automatic queue_access(logic [9:0] va, logic [31:0] now);
        pending_words.push_back({6'b0, now, va});
    endtask

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            expected_results.push_back(translate_access(s_tdata[9:0], s_tdata[41:10]));
            void'(pending_words.pop_front());
        end
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (src_gap > 0)
        begin
            src_gap <= src_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if ((s_tvalid && s_tready) || !s_tvalid)
        begin
            if (s_tvalid && s_tready && !quiet && $urandom_range(0, 9) == 0)
            begin
                src_gap <= $urandom_range(1, 13);
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > (s_tvalid && s_tready ? 1 : 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_words[s_tvalid && s_tready ? 1 : 0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        dtlb_pkg::result_t got;
        dtlb_pkg::result_t want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3], m_tdata[4]};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.tlb_hit !== want.tlb_hit)
                begin
                    $error("tlb_hit expected %0b actual %0b", want.tlb_hit, got.tlb_hit);
                    errors++;
                end
                if (got.page_fault !== want.page_fault)
                begin
                    $error("page_fault expected %0b actual %0b", want.page_fault,
                           got.page_fault);
                    errors++;
                end
                if (got.page_evicted !== want.page_evicted)
                begin
                    $error("page_evicted expected %0b actual %0b", want.page_evicted,
                           got.page_evicted);
                    errors++;
                end
                if (got.cache_hit !== want.cache_hit)
                begin
                    $error("cache_hit expected %0b actual %0b", want.cache_hit,
                           got.cache_hit);
                    errors++;
                end
                if (got.frame_number !== want.frame_number)
                begin
                    $error("frame_number expected %0b actual %0b", want.frame_number,
                           got.frame_number);
                    errors++;
                end
                tlb_hits_seen += want.tlb_hit;
                faults_seen += want.page_fault;
                evictions_seen += want.page_evicted;
                cache_hits_seen += want.cache_hit;
            end
        end
        if (!rst_n || hold_sink)
            m_tready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            sink_gap <= $urandom_range(1, 13);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] clock_now;
        logic [5:0] hot;
        int n;
        for (int i = 0; i < NTLB; i++)
        begin
            tlb_tag[i] = '0;
            tlb_vld[i] = 1'b0;
            tlb_stamp[i] = '0;
        end
        for (int i = 0; i < NPAGES; i++)
        begin
            pg_mapped[i] = 1'b0;
            pg_frame[i] = 1'b0;
            pg_stamp[i] = '0;
        end
        for (int i = 0; i < NSETS; i++)
        begin
            ln_vld[i] = 1'b0;
            ln_tag[i] = '0;
            ln_page[i] = '0;
        end
        frame_ptr = 0;
        mem_full = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_access(10'h000, 32'h0);
        queue_access(10'h000, 32'h0);
        queue_access(10'h004, 32'h1);
        queue_access(10'h3ff, 32'hffff_ffff);
        queue_access(10'h3fc, 32'h2);
        queue_access(10'h155, 32'h3);
        queue_access(10'h2aa, 32'h5555_5555);
        queue_access(10'h00c, 32'haaaa_aaaa);
        for (int p = 0; p < 17; p++)
            queue_access({p[5:0], 4'h8}, 32'h10 + p);
        clock_now = 32'h100;
        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (60) @(posedge clk);

        hold_sink = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            clock_now += 1;
            queue_access(10'($urandom), clock_now);
        end
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (60) @(posedge clk);

        n = 0;
        while (n < 910)
        begin
            hot = 6'($urandom_range(0, 7));
            for (int k = 0; k < 10 && n < 910; k++, n++)
            begin
                clock_now += $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0)
                    queue_access(10'($urandom), $urandom);
                else if ($urandom_range(0, 3) == 0)
                    queue_access(10'($urandom), clock_now);
                else
                    queue_access({hot + 6'($urandom_range(0, 2)), 4'($urandom)}, clock_now);
            end
            if (n > 820)
                quiet = 1'b1;
            wait (pending_words.size() < 20);
        end

        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("Ran %0d accesses: %0d TLB hits, %0d faults, %0d evictions, %0d cache hits",
                 results_seen, tlb_hits_seen, faults_seen, evictions_seen, cache_hits_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
rtl/dtlb_pkg.sv
rtl/dtlb_ram.sv
rtl/data_tlb_page_cache_model.sv
tb/data_tlb_page_cache_model_tb.sv
